@@ rtl/core/fru_type_length_field_decoder_defines.svh @@
// ============================================================================
// FRU type/length decoder assertion macros
// Shared concurrent assertion forms for the decoder's checks.
// ============================================================================
`ifndef FRU_TYPE_LENGTH_FIELD_DECODER_DEFINES_SVH
`define FRU_TYPE_LENGTH_FIELD_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high
`define FRUTL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define FRUTL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/frutl_pkg.sv @@
// ============================================================================
// frutl_pkg
// Types, codes and character maps shared by the FRU type/length decoder.
// ============================================================================
`timescale 1ns / 1ps

package frutl_pkg;

   // Field type, header bits 7:6
   typedef enum logic [1:0] {
      KIND_BINARY    = 2'd0,
      KIND_BCD_PLUS  = 2'd1,
      KIND_SIX_BIT   = 2'd2,
      KIND_EIGHT_BIT = 2'd3
   } kind_type;

   // Byte position inside a three-byte 6-bit group
   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2,
      PHASE_SPARE  = 2'd3
   } phase_type;

   localparam logic [6:0] CHAR_NUL   = 7'h00;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_DASH  = 7'h2D;
   localparam logic [6:0] CHAR_DOT   = 7'h2E;
   localparam logic [6:0] CHAR_QUERY = 7'h3F;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] HEX_ALPHA  = 7'h37;   // 'A' - 10

   // One decoded request's worth of characters (one or two)
   typedef struct packed {
      logic [6:0] char0;
      logic [6:0] char1;
      logic       two_chars;
      kind_type   kind;
      logic       last;
      logic       empty;
   } entry_type;

   function automatic logic [6:0] bcd_plus_char(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib <= 4'd9) begin
         ch = CHAR_ZERO + {3'b000, nib};
      end else if (nib == 4'hA) begin
         ch = CHAR_SPACE;
      end else if (nib == 4'hB) begin
         ch = CHAR_DASH;
      end else if (nib == 4'hC) begin
         ch = CHAR_DOT;
      end else begin
         ch = CHAR_QUERY;
      end
      return ch;
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib <= 4'd9) begin
         ch = CHAR_ZERO + {3'b000, nib};
      end else begin
         ch = HEX_ALPHA + {3'b000, nib};
      end
      return ch;
   endfunction

   // 6-bit packed code to ASCII
   function automatic logic [6:0] six_bit_char(input logic [5:0] code);
      return {1'b0, code} + CHAR_SPACE;
   endfunction

endpackage

@@ rtl/core/frutl_front.sv @@
// ============================================================================
// frutl_front
// Accepts bytes, tracks field headers and decodes each body byte into one
// or two characters that are pushed into the queue as a single entry.
// ============================================================================
`timescale 1ns / 1ps

module frutl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_data,
   input  logic                in_start,
   input  logic                q_full,
   output logic                push,
   output frutl_pkg::entry_type push_entry
);
   import frutl_pkg::*;

   logic      awaiting_ff, awaiting_in;
   kind_type  kind_ff,     kind_in;
   logic [5:0] remain_ff,  remain_in;
   phase_type phase_ff,    phase_in;
   logic [3:0] left_ff,    left_in;

   logic       accept;
   logic       is_header;
   logic [5:0] remain_dec;
   logic       body_last;

   assign in_ready   = !q_full;
   assign accept     = in_valid && !q_full;
   assign is_header  = in_start || awaiting_ff || (remain_ff == 6'd0);
   assign remain_dec = remain_ff - 6'd1;
   assign body_last  = (remain_dec == 6'd0);

   // Header parse and body decode
   always_comb begin
      awaiting_in = awaiting_ff;
      kind_in     = kind_ff;
      remain_in   = remain_ff;
      phase_in    = phase_ff;
      left_in     = left_ff;
      push        = 1'b0;
      push_entry  = '{char0: CHAR_NUL, char1: CHAR_NUL, two_chars: 1'b0,
                      kind: kind_ff, last: 1'b0, empty: 1'b0};
      if (accept) begin
         if (is_header) begin
            kind_in   = kind_type'(in_data[7:6]);
            remain_in = in_data[5:0];
            phase_in  = PHASE_FIRST;
            left_in   = 4'h0;
            if (in_data[5:0] == 6'd0) begin
               // empty field: single marker result
               awaiting_in      = 1'b1;
               push             = 1'b1;
               push_entry.kind  = kind_type'(in_data[7:6]);
               push_entry.last  = 1'b1;
               push_entry.empty = 1'b1;
            end else begin
               awaiting_in = 1'b0;
            end
         end else begin
            remain_in       = remain_dec;
            push            = 1'b1;
            push_entry.last = body_last;
            unique case (kind_ff)
               KIND_EIGHT_BIT: begin
                  push_entry.char0 = in_data[6:0];
               end
               KIND_SIX_BIT: begin
                  case (phase_ff)
                     PHASE_SECOND: begin
                        push_entry.char0 = six_bit_char({in_data[3:0], left_ff[1:0]});
                        left_in          = in_data[7:4];
                        phase_in         = PHASE_THIRD;
                     end
                     PHASE_THIRD: begin
                        push_entry.char0     = six_bit_char({in_data[1:0], left_ff});
                        push_entry.char1     = six_bit_char(in_data[7:2]);
                        push_entry.two_chars = 1'b1;
                        left_in              = 4'h0;
                        phase_in             = PHASE_FIRST;
                     end
                     default: begin
                        push_entry.char0 = six_bit_char(in_data[5:0]);
                        left_in          = {2'b00, in_data[7:6]};
                        phase_in         = PHASE_SECOND;
                     end
                  endcase
               end
               KIND_BCD_PLUS: begin
                  push_entry.char0     = bcd_plus_char(in_data[7:4]);
                  push_entry.char1     = bcd_plus_char(in_data[3:0]);
                  push_entry.two_chars = 1'b1;
               end
               KIND_BINARY: begin
                  push_entry.char0     = hex_char(in_data[7:4]);
                  push_entry.char1     = hex_char(in_data[3:0]);
                  push_entry.two_chars = 1'b1;
               end
               default: begin
                  push_entry.char0 = CHAR_NUL;
               end
            endcase
            // field done: next byte is a header
            if (body_last) begin
               awaiting_in = 1'b1;
               phase_in    = PHASE_FIRST;
               left_in     = 4'h0;
            end
         end
      end
   end

   // Field state
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         kind_ff     <= KIND_BINARY;
         remain_ff   <= 6'd0;
         phase_ff    <= PHASE_FIRST;
         left_ff     <= 4'h0;
      end else begin
         awaiting_ff <= awaiting_in;
         kind_ff     <= kind_in;
         remain_ff   <= remain_in;
         phase_ff    <= phase_in;
         left_ff     <= left_in;
      end
   end

endmodule

@@ rtl/core/frutl_queue.sv @@
// ============================================================================
// frutl_queue
// Two-entry queue between the decode front and the character back end.
// ============================================================================
`timescale 1ns / 1ps

module frutl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  frutl_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 q_valid,
   output logic                 q_full,
   output frutl_pkg::entry_type head_entry
);
   import frutl_pkg::*;

   localparam int Depth = 2;

   entry_type  slots_ff [Depth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_pop;

   assign q_valid    = (count_ff != 2'd0);
   assign q_full     = (count_ff == 2'(Depth));
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && q_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/frutl_back.sv @@
// ============================================================================
// frutl_back
// Takes queue entries and emits their characters one per cycle while out_ready
// is high, through a registered output stage.
// ============================================================================
`timescale 1ns / 1ps

module frutl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  frutl_pkg::entry_type head_entry,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [6:0]           out_char,
   output frutl_pkg::kind_type  out_kind,
   output logic                 out_last,
   output logic                 out_empty
);
   import frutl_pkg::*;

   logic       valid_ff, valid_in;
   logic       sel_ff,   sel_in;
   logic [6:0] char_ff,  char_in;
   kind_type   kind_ff,  kind_in;
   logic       last_ff,  last_in;
   logic       empty_ff, empty_in;
   logic       load;

   assign load      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_kind  = kind_ff;
   assign out_last  = last_ff;
   assign out_empty = empty_ff;

   // Character select and output stage load
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      char_in  = char_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = q_valid;
         if (q_valid) begin
            char_in  = sel_ff ? head_entry.char1 : head_entry.char0;
            kind_in  = head_entry.kind;
            empty_in = head_entry.empty;
            if (head_entry.two_chars && !sel_ff) begin
               // first of a pair: hold the entry
               sel_in  = 1'b1;
               last_in = 1'b0;
            end else begin
               sel_in  = 1'b0;
               last_in = head_entry.last;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

endmodule

@@ rtl/core/fru_type_length_field_decoder.sv @@
// Path: an accepted body byte or empty-field header is written into a queue entry, then its first
//   character is loaded into the output register.
// Throughput: one request per cycle for one-character bytes while rsp_tready
//   is high; bytes that give two characters are held back by the single-character output stage.
// Reset: synchronous, active high; the next request after reset is a header.
// ============================================================================
// fru_type_length_field_decoder
// Decodes FRU type/length-prefixed info fields into an ASCII character stream.
// ============================================================================
`timescale 1ns / 1ps

`include "fru_type_length_field_decoder_defines.svh"

module fru_type_length_field_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] field_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] char_code, [7] zero
   output logic [2:0] rsp_tuser,    // [1:0] field_kind, [2] empty_field
   output logic       rsp_tlast     // last_char
);
   import frutl_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_valid;
   logic      q_full;
   entry_type head_entry;
   logic [6:0] out_char;
   kind_type  out_kind;
   logic      out_empty;

   // Header tracking and byte decode
   frutl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_start   (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue
   frutl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .head_entry (head_entry)
   );

   // Character emission
   frutl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (out_char),
      .out_kind   (out_kind),
      .out_last   (rsp_tlast),
      .out_empty  (out_empty)
   );

   assign rsp_tdata = {1'b0, out_char};
   assign rsp_tuser = {out_empty, out_kind};

   // Checks
   `FRUTL_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tlast && (rsp_tdata == 8'h00), "empty field result not last or not zero")
   `FRUTL_ASSERT_NXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid, "response valid right after reset")
   `FRUTL_ASSERT_NXT(a_rsp_from_queue, clock, reset, !q_valid && !rsp_tvalid, !rsp_tvalid, "response appeared without a queue entry")

endmodule

@@ test/fru_type_length_field_decoder_checker.sv @@
// ============================================================================
// fru_type_length_field_decoder_checker
// Watches both streams of the FRU field decoder. It decodes each accepted
// request with its own copy of the field state and queues the characters it
// expects. Each accepted character is compared with the oldest one queued.
// ============================================================================
`timescale 1ns / 1ps

module fru_type_length_field_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] field_start
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [6:0] char_code, [7] zero
   input  logic [2:0] rsp_tuser,    // [1:0] field_kind, [2] empty_field
   input  logic       rsp_tlast,    // last_char
   output int         fail_count,
   output int         pending,
   output int         checked_count
);
   import frutl_pkg::*;

   typedef struct packed {
      logic [6:0] code;
      kind_type   kind;
      logic       last;
      logic       empty;
   } field_char_type;

   // Characters still owed by the decoder, oldest first
   field_char_type owed_chars[$];
   field_char_type want;

   // Field state mirrored from the decoder
   logic       header_next;
   kind_type   open_kind;
   logic [5:0] body_left;
   phase_type  group_phase;
   logic [3:0] carry_bits;

   function automatic logic [6:0] bcd_plus_ascii(input logic [3:0] nib);
      logic [6:0] ch;
      case (nib)
         4'hA:    ch = 7'h20;   // space
         4'hB:    ch = 7'h2D;   // dash
         4'hC:    ch = 7'h2E;   // dot
         4'hD, 4'hE, 4'hF: ch = 7'h3F;   // '?'
         default: ch = 7'h30 + {3'b000, nib};
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < 4'd10) begin
         ch = 7'h30 + {3'b000, nib};
      end else begin
         ch = 7'h41 + {3'b000, nib - 4'd10};
      end
      return ch;
   endfunction

   task automatic owe_char(input logic [6:0] code, input logic last, input logic empty);
      owed_chars.push_back('{code, open_kind, last, empty});
   endtask

   task automatic report_mismatch(input string note);
      $display("%0t ns  mismatch: %s", $time, note);
      fail_count++;
   endtask

   // Decode one request and queue the characters it yields
   task automatic decode_request(input logic [7:0] b, input logic start);
      logic [6:0] c0;
      logic [6:0] c1;
      logic       two;
      logic       fin;
      if (start || header_next || body_left == 6'd0) begin
         // header: type in 7:6, length in 5:0
         open_kind   = kind_type'(b[7:6]);
         body_left   = b[5:0];
         group_phase = PHASE_FIRST;
         carry_bits  = 4'd0;
         header_next = (b[5:0] == 6'd0);
         if (b[5:0] == 6'd0) begin
            owe_char(7'h00, 1'b1, 1'b1);
         end
      end else begin
         body_left = body_left - 6'd1;
         fin = (body_left == 6'd0);
         two = 1'b0;
         c1  = 7'h00;
         case (open_kind)
            KIND_EIGHT_BIT: begin
               c0 = b[6:0];
            end
            KIND_SIX_BIT: begin
               // packed LSB first: 6 + 2|4 + 4|2 + 6 bits over three bytes
               case (group_phase)
                  PHASE_SECOND: begin
                     c0 = {1'b0, b[3:0], carry_bits[1:0]} + 7'h20;
                     carry_bits  = b[7:4];
                     group_phase = PHASE_THIRD;
                  end
                  PHASE_THIRD: begin
                     c0  = {1'b0, b[1:0], carry_bits} + 7'h20;
                     c1  = {1'b0, b[7:2]} + 7'h20;
                     two = 1'b1;
                     carry_bits  = 4'd0;
                     group_phase = PHASE_FIRST;
                  end
                  default: begin
                     c0 = {1'b0, b[5:0]} + 7'h20;
                     carry_bits  = {2'b00, b[7:6]};
                     group_phase = PHASE_SECOND;
                  end
               endcase
            end
            KIND_BCD_PLUS: begin
               c0  = bcd_plus_ascii(b[7:4]);
               c1  = bcd_plus_ascii(b[3:0]);
               two = 1'b1;
            end
            default: begin
               c0  = hex_ascii(b[7:4]);
               c1  = hex_ascii(b[3:0]);
               two = 1'b1;
            end
         endcase
         if (two) begin
            owe_char(c0, 1'b0, 1'b0);
            owe_char(c1, fin, 1'b0);
         end else begin
            owe_char(c0, fin, 1'b0);
         end
         // a short final 6-bit group just drops its leftover bits
         if (fin) begin
            header_next = 1'b1;
            group_phase = PHASE_FIRST;
            carry_bits  = 4'd0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_chars.delete();
         header_next = 1'b1;
         open_kind   = KIND_BINARY;
         body_left   = 6'd0;
         group_phase = PHASE_FIRST;
         carry_bits  = 4'd0;
         pending     <= 0;
      end else begin
         // compare an accepted character with the oldest one owed
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (owed_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character data %02h user %h last %b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = owed_chars.pop_front();
               if ((rsp_tdata !== {1'b0, want.code}) ||
                   (rsp_tuser !== {want.empty, want.kind}) ||
                   (rsp_tlast !== want.last)) begin
                  report_mismatch($sformatf(
                     "got data %02h user %h last %b, want data %02h user %h last %b",
                     rsp_tdata, rsp_tuser, rsp_tlast, {1'b0, want.code},
                     {want.empty, want.kind}, want.last));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_request(req_tdata, req_tuser);
         end
         pending <= owed_chars.size();
      end
   end

endmodule

@@ test/tb.sv @@
// ============================================================================
// tb
// Directed and random FRU field streams into the decoder, with sender gaps
// and receiver stalls in several phases; the checker scores the characters.
// ============================================================================
`timescale 1ns / 1ps

module tb;
   import frutl_pkg::*;

   localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either side
   localparam int PHASE_ITEMS  = 112;
   localparam int DRAIN_CYCLES = 8;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;      // [7:0] data_byte
   logic       req_tuser  = 1'b0;       // [0] field_start
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;               // [6:0] char_code, [7] zero
   logic [2:0] rsp_tuser;               // [1:0] field_kind, [2] empty_field
   logic       rsp_tlast;               // last_char

   int fail_count;
   int pending;
   int checked_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_count    = 0;
   int field_count   = 0;
   int quiet_cycles  = 0;
   logic need_start  = 1'b0;            // a field was cut off, next header is forced

   fru_type_length_field_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   fru_type_length_field_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One request, with optional idle cycles ahead of it
   task automatic send_request(input logic [7:0] b, input logic start);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Header plus body; cut < len abandons the field after cut body bytes
   task automatic send_field(input kind_type kind, input logic [5:0] len, input int cut);
      send_request({kind, len}, need_start ? 1'b1 : 1'($urandom_range(1)));
      for (int i = 0; i < len && i < cut; i++) begin
         send_request(8'($urandom_range(255)), 1'b0);
      end
      need_start = (cut < len);
      field_count++;
   endtask

   // Hold the sender until every owed character has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [5:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 6'd0;
      if (r < 75) return 6'($urandom_range(6, 1));
      if (r < 92) return 6'($urandom_range(20, 7));
      if (r < 98) return 6'($urandom_range(62, 21));
      return 6'd63;
   endfunction

   task automatic random_fields(input int count);
      int       target;
      logic [5:0] len;
      int       cut;
      target = sent_count + count;
      while (sent_count < target) begin
         if ($urandom_range(99) < 8) begin
            // stray byte with a random start flag
            send_request(8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            len = pick_length();
            cut = ($urandom_range(99) < 8) ? $urandom_range(len) : 64;
            send_field(kind_type'($urandom_range(3)), len, cut);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty fields of every kind, flagged and unflagged
      send_request(8'h00, 1'b0);
      send_request(8'h40, 1'b1);
      send_request(8'h80, 1'b0);
      send_request(8'hC0, 1'b1);
      // eight-bit text, one byte above 0x7F
      send_request(8'hC2, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h41, 1'b0);
      // six-bit full group
      send_request(8'h83, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hA5, 1'b0);
      // six-bit short final group
      send_request(8'h82, 1'b0);
      send_request(8'h3F, 1'b0);
      send_request(8'hFF, 1'b0);
      // BCD plus: digits, space, dash, dot and unmapped nibbles
      send_request(8'h43, 1'b0);
      send_request(8'h09, 1'b0);
      send_request(8'hAB, 1'b0);
      send_request(8'hCF, 1'b0);
      // binary as hex digits
      send_request(8'h02, 1'b0);
      send_request(8'h0F, 1'b0);
      send_request(8'hA9, 1'b0);
      // field abandoned by a forced header
      send_request(8'hC5, 1'b1);
      send_request(8'h41, 1'b0);
      send_request(8'h01, 1'b1);
      send_request(8'h7E, 1'b0);
      field_count += 11;
      wait_drained();

      // random fields: no idling, slow sender, slow receiver, light both
      random_fields(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 85;
      random_fields(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 85;
      random_fields(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 8;
      stall_pct     = 8;
      random_fields(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d bytes in about %0d fields of all four kinds", sent_count,
               field_count);
      $display("%0d characters compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
